[src/pas_pkg.sv]
// Shared types, codes and constants of the periodic ADC sample scheduler.
package pas_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_SOURCES_DEF = 4;
  localparam int MAX_SOURCES     = 4;
  localparam int SRC_IDX_W       = 2;

  localparam int PERIOD_W  = 24;
  localparam int COUNT_W   = 25;
  localparam int TICKS_W   = 16;
  localparam int TAG_W     = 3;
  localparam int CHAN_W    = 5;
  localparam int SEL_W     = 6;
  localparam int SAMPLE_W  = 12;
  localparam int DROP_W    = 8;
  localparam int CFG_ADDR_W = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_BASE = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEL_BASE    = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_END         = 4'd8;

  // Source select reset values
  localparam logic [SEL_W-1:0] SEL_RST_0 = 6'd13;
  localparam logic [SEL_W-1:0] SEL_RST_1 = 6'd12;
  localparam logic [SEL_W-1:0] SEL_RST_2 = 6'd3;
  localparam logic [SEL_W-1:0] SEL_RST_3 = 6'd7;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PUSH = 2'd1,
    OP_DONE = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_PUSH,
    S_DONE,
    S_DISP,
    S_START
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              mux_b;
    logic [CHAN_W-1:0] channel;
  } req_t;

  typedef struct packed {
    logic                 step;
    logic [SRC_IDX_W-1:0] idx;
    logic [PERIOD_W-1:0]  period;
    logic [TICKS_W-1:0]   dt;
  } tick_req_t;

endpackage

[src/periodic_adc_sample_scheduler_top.sv]
// Top level of the periodic ADC sample scheduler: config, sequencer, result register.
//
//  channel | direction | beat carries
//  in_     | slave     | tuser opcode, tdata tick count / pushed request / sample
//  out_    | master    | tuser kind, tlast final result, tdata tag..drop_total
//  cfg_    | slave     | cfg_addr register index, cfg_data value
//
// After an accepted item: a tick has the counter unit handle one source per
// cycle after the accept cycle, then the queue is checked. A push or a done
// item passes through its own state, then the queue check. A start adds a
// state for the registered head read. The item port is ready only in the idle
// state; a waiting result holds the sequencer where it must emit the next one.
// Reset is synchronous; the queue memory is not cleared. Config writes are
// always taken.
module periodic_adc_sample_scheduler_top #(
  parameter int QUEUE_DEPTH = pas_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_SOURCES = pas_pkg::NUM_SOURCES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] elapsed_ticks, [18:16] push_tag, [23:19] push_channel,
  // [24] push_mux_b, [36:25] sample_in, zero above
  input  logic [pas_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] opcode
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] tag, [7:3] channel, [8] mux_b, [20:9] sample_out,
  // [28:21] drop_total, zero above
  output logic [pas_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] kind
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pas_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pas_pkg::PERIOD_W-1:0]        cfg_data
);

  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam logic [SRC_W-1:0] SRC_LAST = SRC_W'(NUM_SOURCES - 1);

  // configuration
  logic [pas_pkg::PERIOD_W-1:0] period_r [pas_pkg::MAX_SOURCES];
  logic [pas_pkg::SEL_W-1:0]    sel_r    [pas_pkg::MAX_SOURCES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pas_pkg::MAX_SOURCES; i++) begin
        period_r[i] <= '0;
      end
      sel_r[0] <= pas_pkg::SEL_RST_0;
      sel_r[1] <= pas_pkg::SEL_RST_1;
      sel_r[2] <= pas_pkg::SEL_RST_2;
      sel_r[3] <= pas_pkg::SEL_RST_3;
    end else if (cfg_valid) begin
      if (cfg_addr < pas_pkg::CFG_SEL_BASE) begin
        period_r[2'(cfg_addr - pas_pkg::CFG_PERIOD_BASE)] <= cfg_data;
      end else if (cfg_addr < pas_pkg::CFG_END) begin
        sel_r[2'(cfg_addr - pas_pkg::CFG_SEL_BASE)] <= cfg_data[pas_pkg::SEL_W-1:0];
      end
    end
  end

  // latched item
  pas_pkg::op_t                  op_r;
  logic [pas_pkg::TICKS_W-1:0]   dt_r;
  pas_pkg::req_t                 preq_r;
  logic [pas_pkg::SAMPLE_W-1:0]  sample_r;

  pas_pkg::state_t state_r, state_nxt;
  logic [SRC_W-1:0] idx_r, idx_nxt;
  logic             busy_r, busy_nxt;
  logic [pas_pkg::TAG_W-1:0]  busy_tag_r, busy_tag_nxt;
  logic [pas_pkg::DROP_W-1:0] drop_count_r, drop_count_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic                          out_last_r, out_last_nxt;
  pas_pkg::req_t                 out_req_r, out_req_nxt;
  logic [pas_pkg::SAMPLE_W-1:0]  out_sample_r, out_sample_nxt;
  logic [pas_pkg::DROP_W-1:0]    out_drop_r, out_drop_nxt;

  logic               accept;
  logic               slot_free;
  logic               load;
  pas_pkg::tick_req_t treq;
  logic               hit;
  logic               q_push, q_pop, q_full, q_empty;
  pas_pkg::req_t      q_wdata, q_rdata;

  assign in_tready = (state_r == pas_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign treq.step   = (state_r == pas_pkg::S_TICK);
  assign treq.idx    = pas_pkg::SRC_IDX_W'(idx_r);
  assign treq.period = period_r[pas_pkg::SRC_IDX_W'(idx_r)];
  assign treq.dt     = dt_r;

  pas_tick #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_tick (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .hit   (hit)
  );

  pas_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .rd_data   (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    busy_nxt       = busy_r;
    busy_tag_nxt   = busy_tag_r;
    drop_count_nxt = drop_count_r;
    q_push         = 1'b0;
    q_pop          = 1'b0;
    q_wdata        = preq_r;
    load           = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_req_nxt    = out_req_r;
    out_sample_nxt = out_sample_r;
    out_drop_nxt   = out_drop_r;

    case (state_r)
      pas_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          case (pas_pkg::op_t'(in_tuser))
            pas_pkg::OP_TICK: state_nxt = pas_pkg::S_TICK;
            pas_pkg::OP_PUSH: state_nxt = pas_pkg::S_PUSH;
            pas_pkg::OP_DONE: state_nxt = pas_pkg::S_DONE;
            default:          state_nxt = pas_pkg::S_IDLE;
          endcase
        end
      end
      pas_pkg::S_TICK: begin
        q_wdata.tag     = pas_pkg::TAG_W'(idx_r);
        q_wdata.mux_b   = sel_r[pas_pkg::SRC_IDX_W'(idx_r)][pas_pkg::CHAN_W];
        q_wdata.channel = sel_r[pas_pkg::SRC_IDX_W'(idx_r)][pas_pkg::CHAN_W-1:0];
        q_push          = hit;
        if (hit && q_full && drop_count_r != pas_pkg::DROP_MAX) begin
          drop_count_nxt = drop_count_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SRC_LAST) begin
          state_nxt = pas_pkg::S_DISP;
        end
      end
      pas_pkg::S_PUSH: begin
        q_push = 1'b1;
        if (q_full && drop_count_r != pas_pkg::DROP_MAX) begin
          drop_count_nxt = drop_count_r + 1'b1;
        end
        state_nxt = pas_pkg::S_DISP;
      end
      pas_pkg::S_DONE: begin
        if (!busy_r) begin
          state_nxt = pas_pkg::S_DISP;
        end else if (slot_free) begin
          load             = 1'b1;
          out_kind_nxt     = pas_pkg::KIND_SAMPLE;
          out_req_nxt      = '0;
          out_req_nxt.tag  = busy_tag_r;
          out_sample_nxt   = sample_r;
          out_drop_nxt     = drop_count_r;
          // a start follows if anything is queued
          out_last_nxt     = q_empty;
          busy_nxt         = 1'b0;
          state_nxt        = pas_pkg::S_DISP;
        end
      end
      pas_pkg::S_DISP: begin
        if (!busy_r && !q_empty) begin
          q_pop     = 1'b1;
          state_nxt = pas_pkg::S_START;
        end else begin
          state_nxt = pas_pkg::S_IDLE;
        end
      end
      pas_pkg::S_START: begin
        if (slot_free) begin
          load           = 1'b1;
          out_kind_nxt   = pas_pkg::KIND_START;
          out_req_nxt    = q_rdata;
          out_sample_nxt = '0;
          out_drop_nxt   = drop_count_r;
          out_last_nxt   = 1'b1;
          busy_nxt       = 1'b1;
          busy_tag_nxt   = q_rdata.tag;
          state_nxt      = pas_pkg::S_IDLE;
        end
      end
      default: state_nxt = pas_pkg::S_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pas_pkg::S_IDLE;
      idx_r        <= '0;
      busy_r       <= 1'b0;
      busy_tag_r   <= '0;
      drop_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      busy_r       <= busy_nxt;
      busy_tag_r   <= busy_tag_nxt;
      drop_count_r <= drop_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r           <= pas_pkg::op_t'(in_tuser);
      dt_r           <= in_tdata[15:0];
      preq_r.tag     <= in_tdata[18:16];
      preq_r.channel <= in_tdata[23:19];
      preq_r.mux_b   <= in_tdata[24];
      sample_r       <= in_tdata[36:25];
    end
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
    out_req_r    <= out_req_nxt;
    out_sample_r <= out_sample_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_drop_r, out_sample_r, out_req_r.mux_b,
                       out_req_r.channel, out_req_r.tag};

  // a start is only issued with the converter idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pas_pkg::S_START && load) |-> !busy_r)
    else $error("start issued while converter busy");

  // a sample is only delivered for an active conversion
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pas_pkg::S_DONE && load) |-> busy_r && op_r == pas_pkg::OP_DONE)
    else $error("sample delivered without an active conversion");

  // drop count never goes backwards
  a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> drop_count_r >= $past(drop_count_r))
    else $error("drop count decreased");

endmodule

[src/pas_fifo.sv]
// Request queue: circular buffer memory with registered head read.
module pas_fifo #(
  parameter int DEPTH = pas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  pas_pkg::req_t              push_data,
  input  logic                       pop,
  output pas_pkg::req_t              rd_data,
  output logic                       full,
  output logic                       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  pas_pkg::req_t mem [DEPTH];
  pas_pkg::req_t rd_data_r;
  logic [PTR_W-1:0] head_r, tail_r;
  logic [LVL_W-1:0] level_r;

  assign full    = (level_r == LVL_W'(DEPTH));
  assign empty   = (level_r == '0);
  assign rd_data = rd_data_r;

  // push and pop are never asserted together by the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      if (push && !full) begin
        tail_r  <= (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
        level_r <= level_r + 1'b1;
      end else if (pop && !empty) begin
        head_r  <= (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
        level_r <= level_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[tail_r] <= push_data;
    end
    if (pop && !empty) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

[src/pas_tick.sv]
// Shared counter unit: adds elapsed ticks to one source counter per step.
module pas_tick #(
  parameter int NUM_SOURCES = pas_pkg::NUM_SOURCES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pas_pkg::tick_req_t req,
  output logic               hit
);

  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [pas_pkg::COUNT_W-1:0] cnt_r [NUM_SOURCES];
  logic [pas_pkg::COUNT_W-1:0] sum;
  logic [pas_pkg::COUNT_W-1:0] cnt_nxt;
  logic                        enabled;
  logic [SRC_W-1:0]            sel;

  assign sel     = req.idx[SRC_W-1:0];
  assign enabled = (req.period != '0);
  assign sum     = cnt_r[sel] + pas_pkg::COUNT_W'(req.dt);
  assign hit     = enabled && (sum >= pas_pkg::COUNT_W'(req.period));

  always_comb begin
    if (!enabled || hit) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (req.step) begin
      cnt_r[sel] <= cnt_nxt;
    end
  end

endmodule
